// File: rtl/core/csm_pkg.sv
package csm_pkg;

  localparam int WIN_DEPTH = 7;
  localparam int SLOT_BITS = 3;
  localparam int WEIGHT_BITS = 4;
  // Largest denominator is 8 + 6 * 15 = 98.
  localparam int DEN_BITS = 7;
  localparam int NUM_EXTRA_BITS = 7;

  localparam logic [WEIGHT_BITS-1:0] CENTER_WEIGHT = 4'd8;

  localparam logic [1:0] CFG_WEIGHT_NEAR = 2'd0;
  localparam logic [1:0] CFG_WEIGHT_MID = 2'd1;
  localparam logic [1:0] CFG_WEIGHT_FAR = 2'd2;

  localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_NEAR = 4'd7;
  localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_MID = 4'd6;
  localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_FAR = 4'd5;

  localparam logic [SLOT_BITS-1:0] SLOT_FULL = 3'd7;

  typedef struct packed {
    logic                   step;
    logic                   first;
    logic                   add;
    logic [WEIGHT_BITS-1:0] weight;
  } acc_ctrl_t;

endpackage

// File: rtl/core/csm_window.sv
module csm_window #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          wr,
  input  logic [csm_pkg::SLOT_BITS-1:0] fill,
  input  logic [COORD_BITS-1:0]         wr_x,
  input  logic [COORD_BITS-1:0]         wr_y,
  input  logic [csm_pkg::SLOT_BITS-1:0] rd_index,
  output logic [COORD_BITS-1:0]         rd_x,
  output logic [COORD_BITS-1:0]         rd_y
);
  import csm_pkg::*;

  logic [COORD_BITS-1:0] ent_x [WIN_DEPTH];
  logic [COORD_BITS-1:0] ent_y [WIN_DEPTH];

  // Until the window is full a new point lands at the fill position;
  // afterwards the window slides by one.
  always_ff @(posedge clk) begin
    if (wr) begin
      if (fill != SLOT_FULL) begin
        ent_x[fill] <= wr_x;
        ent_y[fill] <= wr_y;
      end else begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          ent_x[i] <= ent_x[i+1];
          ent_y[i] <= ent_y[i+1];
        end
        ent_x[WIN_DEPTH-1] <= wr_x;
        ent_y[WIN_DEPTH-1] <= wr_y;
      end
    end
  end

  assign rd_x = ent_x[rd_index];
  assign rd_y = ent_y[rd_index];

endmodule

// File: rtl/core/csm_accum.sv
module csm_accum #(
  parameter int COORD_BITS = 16
) (
  input  logic                                                clk,
  input  csm_pkg::acc_ctrl_t                                  ctrl,
  input  logic [COORD_BITS-1:0]                               px,
  input  logic [COORD_BITS-1:0]                               py,
  output logic [COORD_BITS+csm_pkg::NUM_EXTRA_BITS-1:0]       num_x,
  output logic [COORD_BITS+csm_pkg::NUM_EXTRA_BITS-1:0]       num_y,
  output logic [csm_pkg::DEN_BITS-1:0]                        den
);
  import csm_pkg::*;

  localparam int NW = COORD_BITS + NUM_EXTRA_BITS;
  localparam int PW = COORD_BITS + WEIGHT_BITS;

  logic [PW-1:0]       prod_x;
  logic [PW-1:0]       prod_y;
  logic [NW-1:0]       base_x;
  logic [NW-1:0]       base_y;
  logic [DEN_BITS-1:0] base_den;

  assign prod_x = PW'(ctrl.weight) * PW'(px);
  assign prod_y = PW'(ctrl.weight) * PW'(py);

  assign base_x = ctrl.first ? '0 : num_x;
  assign base_y = ctrl.first ? '0 : num_y;
  assign base_den = ctrl.first ? '0 : den;

  // One window tap per cycle; taps outside the kernel are skipped so that
  // entries never written do not enter the sum.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      if (ctrl.add) begin
        num_x <= base_x + NW'(prod_x);
        num_y <= base_y + NW'(prod_y);
        den <= base_den + DEN_BITS'(ctrl.weight);
      end else begin
        num_x <= base_x;
        num_y <= base_y;
        den <= base_den;
      end
    end
  end

endmodule

// File: rtl/core/csm_divider.sv
module csm_divider #(
  parameter int COORD_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          load,
  input  logic                                          step,
  input  logic [COORD_BITS+csm_pkg::NUM_EXTRA_BITS-1:0] num,
  input  logic [csm_pkg::DEN_BITS-1:0]                  den,
  output logic [COORD_BITS-1:0]                         quot
);
  import csm_pkg::*;

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  assign shifted = {rem, quot[COORD_BITS-1]};
  assign trial = shifted - {1'b0, den};
  assign fits = shifted >= {1'b0, den};

  // Restoring division, one quotient bit per cycle. The quotient never
  // exceeds the largest coordinate, so the high part of the numerator is
  // already below the denominator and only COORD_BITS steps are needed.
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= num[COORD_BITS+NUM_EXTRA_BITS-1:COORD_BITS];
      quot <= num[COORD_BITS-1:0];
    end else if (step) begin
      rem <= fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
      quot <= {quot[COORD_BITS-2:0], fits};
    end
  end

endmodule

// File: rtl/core/contour_segment_smoother_core.sv
// Contour segment smoother.
// Points of a contour segment enter on the point channel (point_x, point_y,
// last_point marking the final point). One result per interior point leaves
// on the smooth channel; segment_done marks the final result of a segment.
// Segments of six points or fewer pass interior points through; longer ones
// get a normalized weighted average of up to 7 taps per coordinate, floored.
// The weights are to be set through cfg_write/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Each result walks the
// window taps through one multiply-add per coordinate, loads the divider,
// runs the bit-serial restoring divider and moves into the output register.
// A point that produces results holds point_stall high until its last
// result has entered the output register.
// The output register lets the next point be taken while the last result
// still waits. If smooth_stall stays high, the engine waits with its next
// result finished and the point channel stays stalled.
// Reset clears the weights to 7, 6 and 5, empties the window and drops
// any pending result.
module contour_segment_smoother_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  last_point,
  output logic                  smooth_valid,
  input  logic                  smooth_stall,
  output logic [COORD_BITS-1:0] smooth_x,
  output logic [COORD_BITS-1:0] smooth_y,
  output logic                  segment_done,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [3:0]            cfg_data
);
  import csm_pkg::*;

  localparam int NW = COORD_BITS + NUM_EXTRA_BITS;
  localparam int CNT_BITS = $clog2(COORD_BITS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  logic [2:0]             state;
  logic [SLOT_BITS-1:0]   points_seen;
  logic [SLOT_BITS-1:0]   slot;
  logic [SLOT_BITS-1:0]   slot_last;
  logic                   smooth_mode;
  logic                   seg_end;
  logic [SLOT_BITS-1:0]   tap;
  logic [CNT_BITS-1:0]    div_cnt;
  logic [WEIGHT_BITS-1:0] weight_near;
  logic [WEIGHT_BITS-1:0] weight_mid;
  logic [WEIGHT_BITS-1:0] weight_far;

  logic                   accept;
  logic [SLOT_BITS-1:0]   count_next;
  logic                   fresh;
  logic                   job_any;
  logic                   job_smooth;
  logic [SLOT_BITS-1:0]   job_first;
  logic [SLOT_BITS-1:0]   job_last;
  logic [SLOT_BITS-1:0]   points_seen_next;

  logic [SLOT_BITS-1:0]   tap_gap;
  acc_ctrl_t              acc_ctrl;
  logic [COORD_BITS-1:0]  tap_x;
  logic [COORD_BITS-1:0]  tap_y;
  logic [NW-1:0]          num_x;
  logic [NW-1:0]          num_y;
  logic [DEN_BITS-1:0]    den;
  logic [COORD_BITS-1:0]  quot_x;
  logic [COORD_BITS-1:0]  quot_y;
  logic                   out_free;
  logic                   out_load;

  assign point_stall = (state != ST_IDLE);
  assign accept = point_valid && !point_stall;
  assign out_free = !smooth_valid || !smooth_stall;
  assign out_load = (state == ST_OUT) && out_free;

  // Work out which window slots produce results for the incoming point.
  always_comb begin
    count_next = (points_seen == SLOT_FULL) ? SLOT_FULL : points_seen + 3'd1;
    fresh = (points_seen == 3'd6);
    job_any = 1'b0;
    job_smooth = 1'b1;
    job_first = 3'd3;
    job_last = 3'd3;
    if (last_point) begin
      points_seen_next = '0;
      if (count_next != SLOT_FULL) begin
        job_smooth = 1'b0;
        job_any = (count_next >= 3'd3);
        job_first = 3'd1;
        job_last = count_next - 3'd2;
      end else begin
        job_any = 1'b1;
        job_first = fresh ? 3'd1 : 3'd3;
        job_last = 3'd5;
      end
    end else begin
      points_seen_next = count_next;
      if (fresh) begin
        job_any = 1'b1;
        job_first = 3'd1;
        job_last = 3'd3;
      end else if (points_seen == SLOT_FULL) begin
        job_any = 1'b1;
      end
    end
  end

  // Kernel weight for the current tap relative to the slot being smoothed.
  always_comb begin
    tap_gap = (tap > slot) ? tap - slot : slot - tap;
    acc_ctrl.step = (state == ST_ACC);
    acc_ctrl.first = (tap == '0);
    acc_ctrl.add = smooth_mode ? (tap_gap <= 3'd3) : (tap_gap == '0);
    unique case (tap_gap)
      3'd0: acc_ctrl.weight = CENTER_WEIGHT;
      3'd1: acc_ctrl.weight = weight_near;
      3'd2: acc_ctrl.weight = weight_mid;
      default: acc_ctrl.weight = weight_far;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_near <= RESET_WEIGHT_NEAR;
      weight_mid <= RESET_WEIGHT_MID;
      weight_far <= RESET_WEIGHT_FAR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WEIGHT_NEAR: weight_near <= cfg_data;
        CFG_WEIGHT_MID: weight_mid <= cfg_data;
        CFG_WEIGHT_FAR: weight_far <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      points_seen <= '0;
      smooth_valid <= 1'b0;
      slot <= '0;
      slot_last <= '0;
      smooth_mode <= 1'b0;
      seg_end <= 1'b0;
      tap <= '0;
      div_cnt <= '0;
    end else begin
      if (out_load) begin
        smooth_valid <= 1'b1;
      end else if (!smooth_stall) begin
        smooth_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            points_seen <= points_seen_next;
            slot <= job_first;
            slot_last <= job_last;
            smooth_mode <= job_smooth;
            seg_end <= last_point;
            tap <= '0;
            if (job_any) begin
              state <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          if (tap == 3'(WIN_DEPTH - 1)) begin
            state <= ST_LOAD;
          end else begin
            tap <= tap + 3'd1;
          end
        end
        ST_LOAD: begin
          div_cnt <= CNT_BITS'(COORD_BITS - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_OUT;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            tap <= '0;
            if (slot == slot_last) begin
              state <= ST_IDLE;
            end else begin
              slot <= slot + 3'd1;
              state <= ST_ACC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      smooth_x <= quot_x;
      smooth_y <= quot_y;
      segment_done <= seg_end && (slot == slot_last);
    end
  end

  csm_window #(
    .COORD_BITS(COORD_BITS)
  ) u_window (
    .clk(clk),
    .wr(accept),
    .fill(points_seen),
    .wr_x(point_x),
    .wr_y(point_y),
    .rd_index(tap),
    .rd_x(tap_x),
    .rd_y(tap_y)
  );

  csm_accum #(
    .COORD_BITS(COORD_BITS)
  ) u_accum (
    .clk(clk),
    .ctrl(acc_ctrl),
    .px(tap_x),
    .py(tap_y),
    .num_x(num_x),
    .num_y(num_y),
    .den(den)
  );

  csm_divider #(
    .COORD_BITS(COORD_BITS)
  ) u_div_x (
    .clk(clk),
    .load(state == ST_LOAD),
    .step(state == ST_DIV),
    .num(num_x),
    .den(den),
    .quot(quot_x)
  );

  csm_divider #(
    .COORD_BITS(COORD_BITS)
  ) u_div_y (
    .clk(clk),
    .load(state == ST_LOAD),
    .step(state == ST_DIV),
    .num(num_y),
    .den(den),
    .quot(quot_y)
  );

endmodule

// File: dv/tb_top.sv
module tb_top;
  import csm_pkg::*;

  localparam int CW = 16;
  // Cycles to let the engine go quiet once every expected result has been taken.
  localparam int DRAIN_CYCLES = 160;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          done;
  } smooth_t;

  typedef enum {PAT_ALT, PAT_MAX, PAT_WALK, PAT_NOISE} pattern_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          point_valid = 1'b0;
  logic          point_stall;
  logic [CW-1:0] point_x = '0;
  logic [CW-1:0] point_y = '0;
  logic          last_point = 1'b0;
  logic          smooth_valid;
  logic          smooth_stall = 1'b0;
  logic [CW-1:0] smooth_x;
  logic [CW-1:0] smooth_y;
  logic          segment_done;
  logic          cfg_write = 1'b0;
  logic [1:0]    cfg_index = CFG_WEIGHT_NEAR;
  logic [3:0]    cfg_data = '0;

  // Predictor state: the sliding point window, fill count and weights.
  logic [CW-1:0]          win_x [WIN_DEPTH];
  logic [CW-1:0]          win_y [WIN_DEPTH];
  int                     fill_count = 0;
  logic [WEIGHT_BITS-1:0] w_near = RESET_WEIGHT_NEAR;
  logic [WEIGHT_BITS-1:0] w_mid = RESET_WEIGHT_MID;
  logic [WEIGHT_BITS-1:0] w_far = RESET_WEIGHT_FAR;

  smooth_t pending_smooth[$];

  int errors = 0;
  int points_sent = 0;
  int segments_sent = 0;
  int results_checked = 0;
  int weight_writes = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int hold_left = 0;
  int pressure_req = 0;
  bit quiet = 1'b0;

  contour_segment_smoother_core #(.COORD_BITS(CW)) DUT (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point),
    .smooth_valid (smooth_valid),
    .smooth_stall (smooth_stall),
    .smooth_x     (smooth_x),
    .smooth_y     (smooth_y),
    .segment_done (segment_done),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Contour-like step from the previous coordinate, with occasional jumps.
  function automatic logic [CW-1:0] wander(input logic [CW-1:0] v);
    int r;
    int s;
    r = $urandom_range(99);
    if (r < 75) begin
      s = int'(v) + int'($urandom_range(0, 128)) - 64;
      if (s < 0) s = 0;
      if (s > 65535) s = 65535;
      return s[CW-1:0];
    end
    if (r < 92) return CW'($urandom);
    return r[0] ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic logic [CW-1:0] smooth_coord(input int m, input bit axis_y);
    longint num;
    longint den;
    longint w;
    int d;
    num = 8 * longint'(axis_y ? win_y[m] : win_x[m]);
    den = 8;
    for (d = 1; d <= 3; d++) begin
      w = (d == 1) ? w_near : (d == 2) ? w_mid : w_far;
      if (m - d >= 0) begin
        num += w * longint'(axis_y ? win_y[m-d] : win_x[m-d]);
        den += w;
      end
      if (m + d <= WIN_DEPTH - 1) begin
        num += w * longint'(axis_y ? win_y[m+d] : win_x[m+d]);
        den += w;
      end
    end
    return CW'(num / den);
  endfunction

  // Updates the window with one accepted point and queues the results it causes.
  task automatic track_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic last);
    int c;
    int i;
    bit fresh;
    smooth_t item;
    smooth_t batch[$];
    c = fill_count;
    fresh = (c == 6);
    if (c < WIN_DEPTH) begin
      win_x[c] = x;
      win_y[c] = y;
      c++;
    end else begin
      for (i = 0; i < WIN_DEPTH - 1; i++) begin
        win_x[i] = win_x[i+1];
        win_y[i] = win_y[i+1];
      end
      win_x[WIN_DEPTH-1] = x;
      win_y[WIN_DEPTH-1] = y;
    end
    if (last) begin
      if (c <= 6) begin
        for (i = 1; i <= c - 2; i++) begin
          item = '{win_x[i], win_y[i], 1'b0};
          batch.insert(batch.size(), item);
        end
      end else begin
        for (i = fresh ? 1 : 3; i <= 5; i++) begin
          item = '{smooth_coord(i, 0), smooth_coord(i, 1), 1'b0};
          batch.insert(batch.size(), item);
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].done = 1'b1;
      fill_count = 0;
    end else begin
      if (fresh) begin
        for (i = 1; i <= 3; i++) begin
          item = '{smooth_coord(i, 0), smooth_coord(i, 1), 1'b0};
          batch.insert(batch.size(), item);
        end
      end else if (c == WIN_DEPTH) begin
        item = '{smooth_coord(3, 0), smooth_coord(3, 1), 1'b0};
        batch.insert(batch.size(), item);
      end
      fill_count = c;
    end
    foreach (batch[k]) pending_smooth.insert(pending_smooth.size(), batch[k]);
  endtask

  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic last);
    int gap;
    gap = quiet ? 0 : rand_gap();
    @(negedge clk);
    if (gap > 0) begin
      point_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_x = x;
    point_y = y;
    last_point = last;
    point_valid = 1'b1;
    do @(posedge clk); while (point_stall);
    track_point(x, y, last);
    points_sent++;
  endtask

  task automatic send_segment(input int len, input pattern_t kind);
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    int i;
    x = CW'($urandom);
    y = CW'($urandom);
    for (i = 0; i < len; i++) begin
      case (kind)
        PAT_ALT: begin
          case (i % 4)
            0: begin x = 16'h0000; y = 16'hFFFF; end
            1: begin x = 16'hFFFF; y = 16'h0000; end
            2: begin x = 16'hAAAA; y = 16'h5555; end
            default: begin x = 16'h5555; y = 16'hAAAA; end
          endcase
        end
        PAT_MAX: begin
          x = 16'hFFFF;
          y = 16'hFFFF;
        end
        PAT_WALK: begin
          x = wander(x);
          y = wander(y);
        end
        default: begin
          x = CW'($urandom);
          y = CW'($urandom);
        end
      endcase
      send_point(x, y, i == len - 1);
    end
    segments_sent++;
  endtask

  // Waits until every expected result is out and the engine has gone quiet.
  task automatic settle();
    @(negedge clk);
    point_valid = 1'b0;
    while (pending_smooth.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_write = 1'b1;
    @(posedge clk);
    case (idx)
      CFG_WEIGHT_NEAR: w_near = val;
      CFG_WEIGHT_MID: w_mid = val;
      CFG_WEIGHT_FAR: w_far = val;
      default: ;
    endcase
    weight_writes++;
  endtask

  task automatic set_weights(input logic [3:0] near_w, input logic [3:0] mid_w,
                             input logic [3:0] far_w);
    settle();
    write_reg(CFG_WEIGHT_NEAR, near_w);
    write_reg(CFG_WEIGHT_MID, mid_w);
    write_reg(CFG_WEIGHT_FAR, far_w);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Short segments pass through or stay silent; 7 and 8 points start smoothing.
  task automatic test_directed();
    send_segment(1, PAT_ALT);
    send_segment(2, PAT_ALT);
    send_segment(6, PAT_ALT);
    send_segment(7, PAT_MAX);
    send_segment(8, PAT_ALT);
  endtask

  task automatic test_weight_extremes();
    set_weights(4'd0, 4'd0, 4'd0);
    send_segment(7, PAT_ALT);
    send_segment(10, PAT_WALK);
    set_weights(4'd15, 4'd15, 4'd15);
    send_segment(7, PAT_ALT);
    send_segment(10, PAT_WALK);
    set_weights(4'd8, 4'd8, 4'd8);
    send_segment(7, PAT_MAX);
    send_segment(10, PAT_NOISE);
    set_weights(4'd15, 4'd0, 4'd15);
    send_segment(7, PAT_ALT);
    send_segment(10, PAT_WALK);
    set_weights(4'd0, 4'd15, 4'd8);
    send_segment(7, PAT_ALT);
    send_segment(10, PAT_NOISE);
  endtask

  // The receiver holds off while a long segment keeps coming, so the block backs up.
  task automatic test_output_holdoff();
    quiet = 1'b1;
    pressure_req = HOLD_CYCLES;
    send_segment(30, PAT_WALK);
    quiet = 1'b0;
  endtask

  task automatic test_random_segments();
    int first_point;
    int r;
    int len;
    pattern_t kind;
    first_point = points_sent;
    quiet = 1'b1;
    while (points_sent - first_point < 300) begin
      if (points_sent - first_point > 60) quiet = 1'b0;
      if ($urandom_range(5) == 0)
        set_weights(4'($urandom_range(15)), 4'($urandom_range(15)),
                    4'($urandom_range(15)));
      r = $urandom_range(99);
      if (r < 20) len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 24);
      else len = $urandom_range(25, 40);
      r = $urandom_range(99);
      if (r < 70) kind = PAT_WALK;
      else if (r < 85) kind = PAT_NOISE;
      else if (r < 95) kind = PAT_ALT;
      else kind = PAT_MAX;
      send_segment(len, kind);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_weight_extremes();
    test_output_holdoff();
    test_random_segments();
    settle();
    $display("Sent %0d points in %0d segments, checked %0d smoothed points, %0d weight writes.",
             points_sent, segments_sent, results_checked, weight_writes);
    $display("Segments of 1 to 40 points, weights from 0 to 15, random gaps and a long hold-off.");
    if (errors == 0 && pending_smooth.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Output side stall: random gaps, quiet stretches, and the long hold-off on request.
  always @(negedge clk) begin
    if (pressure_req > 0) begin
      hold_left = pressure_req;
      pressure_req = 0;
    end
    if (hold_left > 0) begin
      smooth_stall = 1'b1;
      hold_left--;
    end else if (quiet) begin
      smooth_stall = 1'b0;
    end else if (stall_left > 0) begin
      smooth_stall = 1'b1;
      stall_left--;
    end else begin
      smooth_stall = 1'b0;
      stall_left = rand_gap();
    end
  end

  always @(posedge clk) begin : check_smooth
    smooth_t want;
    if (!rst && smooth_valid && !smooth_stall) begin
      if (pending_smooth.size() == 0) begin
        $display("%0t: unexpected transaction x=%h y=%h done=%b",
                 $time, smooth_x, smooth_y, segment_done);
        errors++;
      end else begin
        want = pending_smooth.pop_front();
        results_checked++;
        if (smooth_x !== want.x) begin
          $display("%0t: smooth_x expected %h got %h", $time, want.x, smooth_x);
          errors++;
        end
        if (smooth_y !== want.y) begin
          $display("%0t: smooth_y expected %h got %h", $time, want.y, smooth_y);
          errors++;
        end
        if (segment_done !== want.done) begin
          $display("%0t: segment_done expected %b got %b", $time, want.done, segment_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (smooth_valid && !smooth_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results still expected",
                 $time, idle_cycles, pending_smooth.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
